### hw/rtl/pcb_pkg.sv
// ---------------------------------------------------------------------------
// pcb_pkg: shared types and codes for the point clip test
// Command codes, cause codes, word indexes and the issue/control structs.
// ---------------------------------------------------------------------------
package pcb_pkg;

  // input commands
  localparam logic [1:0] CMD_BOX_WR = 2'd0;
  localparam logic [1:0] CMD_PLN_WR = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // result causes
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_BOX   = 2'd1;
  localparam logic [1:0] CAUSE_PLANE = 2'd2;
  localparam logic [1:0] CAUSE_POLY  = 2'd3;

  // box word indexes
  localparam logic [3:0] BW_MAT_LAST = 4'd8;
  localparam logic [3:0] BW_TR_FIRST = 4'd9;
  localparam logic [3:0] BW_TR_LAST  = 4'd11;
  localparam logic [3:0] BW_FLAG     = 4'd12;
  localparam logic [3:0] BW_MASK     = 4'd13;

  // plane word indexes
  localparam logic [3:0] PW_NRM_LAST = 4'd2;
  localparam logic [3:0] PW_OFS      = 4'd3;
  localparam logic [3:0] PW_INV      = 4'd4;
  localparam logic [3:0] PW_MASK     = 4'd5;

  // box walk: three translation reads then nine matrix reads
  localparam logic [3:0] BOX_STEPS_LAST = 4'd11;
  localparam logic [3:0] BOX_OFS_STEPS  = 4'd3;
  localparam logic [3:0] PLN_STEPS_LAST = 4'd2;
  localparam logic [1:0] COL_LAST       = 2'd2;
  localparam logic [3:0] ROW0_LAST_WORD = 4'd2;

  // accumulator and box window [-0.5, 0.5) scaled to the Q8.24 x Q24.8 sum
  localparam int ACC_W = 68;
  localparam logic signed [ACC_W-1:0] BOX_LO = -(68'sd2147483648);
  localparam logic signed [ACC_W-1:0] BOX_HI = 68'sd2147483648;
  localparam int PLN_SHIFT = 24;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BOX_OFS,
    OP_BOX_MAT,
    OP_PLN_NRM
  } op_t;

  // one table read issued by the controller
  typedef struct packed {
    op_t        op;
    logic [7:0] entry;
    logic [3:0] word;
    logic [1:0] col;
  } issue_t;

  typedef struct packed {
    logic   accept;
    logic   query_start;
    logic   load_result;
    logic   load_zero;
    issue_t iss;
  } ctl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } ctl_sts_t;

endpackage

### hw/rtl/pcb_datapath.sv
// ---------------------------------------------------------------------------
// pcb_datapath: tables and shared multiply-accumulate path
// Holds box and plane tables, walks issued reads through a read stage,
// a multiply stage and an accumulate/compare stage, and keeps the result.
// ---------------------------------------------------------------------------
module pcb_datapath import pcb_pkg::*; #(
  parameter int MAX_ENTRIES = 32,
  parameter int MODEL_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_cmd,
  input  logic [4:0]         in_entry_index,
  input  logic [3:0]         in_word_index,
  input  logic signed [31:0] in_word_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [3:0]         in_model_slot,
  input  logic               in_polygon_cut,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  output logic               out_cut,
  output logic [1:0]         out_cause
);

  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int E3W = $clog2(MAX_ENTRIES * 3);
  localparam int E9W = $clog2(MAX_ENTRIES * 9);

  // tables
  logic signed [31:0]     bmat_mem [MAX_ENTRIES*9];
  logic signed [31:0]     bofs_mem [MAX_ENTRIES*3];
  logic                   bflg_mem [MAX_ENTRIES];
  logic [MODEL_SLOTS-1:0] bmsk_mem [MAX_ENTRIES];
  logic signed [31:0]     pnrm_mem [MAX_ENTRIES*3];
  logic signed [31:0]     pofs_mem [MAX_ENTRIES];
  logic                   pflg_mem [MAX_ENTRIES];
  logic [MODEL_SLOTS-1:0] pmsk_mem [MAX_ENTRIES];

  // write decode
  logic wr_ok, wr_box, wr_pln;
  logic we_bmat, we_bofs, we_bflg, we_bmsk, we_pnrm, we_pofs, we_pflg, we_pmsk;
  logic [EW-1:0]  wa_e;
  logic [E9W-1:0] wa_mat;
  logic [E3W-1:0] wa_bofs, wa_pnrm;
  logic [MODEL_SLOTS-1:0] wr_mask;
  logic wr_flag;

  assign wr_ok   = cmd.accept && ({27'b0, in_entry_index} < MAX_ENTRIES);
  assign wr_box  = wr_ok && (in_cmd == CMD_BOX_WR);
  assign wr_pln  = wr_ok && (in_cmd == CMD_PLN_WR);
  assign we_bmat = wr_box && (in_word_index <= BW_MAT_LAST);
  assign we_bofs = wr_box && (in_word_index >= BW_TR_FIRST) && (in_word_index <= BW_TR_LAST);
  assign we_bflg = wr_box && (in_word_index == BW_FLAG);
  assign we_bmsk = wr_box && (in_word_index == BW_MASK);
  assign we_pnrm = wr_pln && (in_word_index <= PW_NRM_LAST);
  assign we_pofs = wr_pln && (in_word_index == PW_OFS);
  assign we_pflg = wr_pln && (in_word_index == PW_INV);
  assign we_pmsk = wr_pln && (in_word_index == PW_MASK);

  assign wa_e    = EW'(in_entry_index);
  assign wa_mat  = E9W'(16'(in_entry_index) * 16'd9 + 16'(in_word_index));
  assign wa_bofs = E3W'(16'(in_entry_index) * 16'd3 + 16'(in_word_index)
                        - 16'(BW_TR_FIRST));
  assign wa_pnrm = E3W'(16'(in_entry_index) * 16'd3 + 16'(in_word_index));
  assign wr_mask = MODEL_SLOTS'({32'b0, in_word_value});
  assign wr_flag = |in_word_value;

  // read addresses from the issued step
  logic [EW-1:0]  ra_e;
  logic [E9W-1:0] ra_mat;
  logic [E3W-1:0] ra_3;

  assign ra_e   = EW'(cmd.iss.entry);
  assign ra_mat = E9W'(16'(cmd.iss.entry) * 16'd9 + 16'(cmd.iss.word));
  assign ra_3   = E3W'(16'(cmd.iss.entry) * 16'd3 + 16'(cmd.iss.col));

  logic signed [31:0]     rd_mat_r, rd_bofs_r, rd_pnrm_r, rd_pofs_r;
  logic                   rd_bflg_r, rd_pflg_r;
  logic [MODEL_SLOTS-1:0] rd_bmsk_r, rd_pmsk_r;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (we_bmat) bmat_mem[wa_mat] <= in_word_value;
    if (we_bofs) bofs_mem[wa_bofs] <= in_word_value;
    if (we_bflg) bflg_mem[wa_e] <= wr_flag;
    if (we_bmsk) bmsk_mem[wa_e] <= wr_mask;
    if (we_pnrm) pnrm_mem[wa_pnrm] <= in_word_value;
    if (we_pofs) pofs_mem[wa_e] <= in_word_value;
    if (we_pflg) pflg_mem[wa_e] <= wr_flag;
    if (we_pmsk) pmsk_mem[wa_e] <= wr_mask;
    rd_mat_r  <= bmat_mem[ra_mat];
    rd_bofs_r <= bofs_mem[ra_3];
    rd_bflg_r <= bflg_mem[ra_e];
    rd_bmsk_r <= bmsk_mem[ra_e];
    rd_pnrm_r <= pnrm_mem[ra_3];
    rd_pofs_r <= pofs_mem[ra_e];
    rd_pflg_r <= pflg_mem[ra_e];
    rd_pmsk_r <= pmsk_mem[ra_e];
  end

  // query operands
  logic signed [31:0] pos_r [3];
  logic [3:0]         slot_r;
  logic               poly_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      slot_r   <= in_model_slot;
      poly_r   <= in_polygon_cut;
    end
  end

  // pipeline control
  issue_t iss1_r, iss2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss1_r <= '0;
      iss2_r <= '0;
    end else begin
      iss1_r <= cmd.iss;
      iss2_r <= iss1_r;
    end
  end

  assign sts.pipe_busy = (iss1_r.op != OP_NONE) || (iss2_r.op != OP_NONE);

  // multiply stage: translated coordinate or raw point times table entry
  logic signed [32:0]     d_r [3];
  logic signed [32:0]     mul_a;
  logic signed [31:0]     mul_b;
  logic signed [64:0]     prod_r;
  logic                   bflg_r, pflg_r;
  logic [MODEL_SLOTS-1:0] bmsk_r, pmsk_r;
  logic signed [31:0]     pofs_r;

  assign mul_a = (iss1_r.op == OP_BOX_MAT) ? d_r[iss1_r.col] : 33'(pos_r[iss1_r.col]);
  assign mul_b = (iss1_r.op == OP_BOX_MAT) ? rd_mat_r : rd_pnrm_r;

  always_ff @(posedge clk) begin
    prod_r <= 65'(mul_a) * 65'(mul_b);
    if (iss1_r.op == OP_BOX_OFS) begin
      d_r[iss1_r.col] <= 33'(pos_r[iss1_r.col]) - 33'(rd_bofs_r);
    end
    if (iss1_r.op == OP_BOX_OFS && iss1_r.col == 2'd0) begin
      bflg_r <= rd_bflg_r;
      bmsk_r <= rd_bmsk_r;
    end
    if (iss1_r.op == OP_PLN_NRM && iss1_r.col == 2'd0) begin
      pflg_r <= rd_pflg_r;
      pmsk_r <= rd_pmsk_r;
      pofs_r <= rd_pofs_r;
    end
  end

  // accumulate and compare stage
  logic signed [ACC_W-1:0] acc_r, acc_sum, pln_lim;
  logic [63:0] bmsk_ext, pmsk_ext;
  logic        box_appl, pln_appl, row_in, box_in_nxt, above;
  logic        box_in_r, any_sub_r, any_add_r, in_add_r, pln_cut_r;

  assign acc_sum    = ((iss2_r.col == 2'd0) ? '0 : acc_r) + ACC_W'(prod_r);
  assign bmsk_ext   = 64'(bmsk_r);
  assign pmsk_ext   = 64'(pmsk_r);
  assign box_appl   = bmsk_ext[6'(slot_r)];
  assign pln_appl   = pmsk_ext[6'(slot_r)];
  assign row_in     = (acc_sum >= BOX_LO) && (acc_sum < BOX_HI);
  assign box_in_nxt = row_in && ((iss2_r.word == ROW0_LAST_WORD) || box_in_r);
  assign pln_lim    = ACC_W'(pofs_r) <<< PLN_SHIFT;
  assign above      = acc_sum > pln_lim;

  always_ff @(posedge clk) begin
    if (iss2_r.op == OP_BOX_MAT || iss2_r.op == OP_PLN_NRM) acc_r <= acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_in_r  <= 1'b0;
      any_sub_r <= 1'b0;
      any_add_r <= 1'b0;
      in_add_r  <= 1'b0;
      pln_cut_r <= 1'b0;
    end else if (cmd.query_start) begin
      any_sub_r <= 1'b0;
      any_add_r <= 1'b0;
      in_add_r  <= 1'b0;
      pln_cut_r <= 1'b0;
    end else if (iss2_r.col == COL_LAST) begin
      if (iss2_r.op == OP_BOX_MAT) begin
        box_in_r <= box_in_nxt;
        if (iss2_r.word == BW_MAT_LAST && box_appl) begin
          if (bflg_r) begin
            any_sub_r <= any_sub_r | box_in_nxt;
          end else begin
            any_add_r <= 1'b1;
            in_add_r  <= in_add_r | box_in_nxt;
          end
        end
      end else if (iss2_r.op == OP_PLN_NRM) begin
        if (pln_appl && (pflg_r ? !above : above)) pln_cut_r <= 1'b1;
      end
    end
  end

  // result register
  logic       box_cut;
  logic       out_cut_r;
  logic [1:0] out_cause_r;

  assign box_cut = any_sub_r || (any_add_r && !in_add_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_zero) begin
      out_cut_r   <= 1'b0;
      out_cause_r <= CAUSE_NONE;
    end else if (cmd.load_result) begin
      priority if (box_cut) begin
        out_cut_r   <= 1'b1;
        out_cause_r <= CAUSE_BOX;
      end else if (pln_cut_r) begin
        out_cut_r   <= 1'b1;
        out_cause_r <= CAUSE_PLANE;
      end else if (poly_r) begin
        out_cut_r   <= 1'b1;
        out_cause_r <= CAUSE_POLY;
      end else begin
        out_cut_r   <= 1'b0;
        out_cause_r <= CAUSE_NONE;
      end
    end
  end

  assign out_cut   = out_cut_r;
  assign out_cause = out_cause_r;

  // checks
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    iss2_r.op == $past(iss1_r.op))
    else $error("pipeline stage skipped");
  a_cut_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_cut_r == (out_cause_r != CAUSE_NONE))
    else $error("cut and cause disagree");

endmodule

### hw/rtl/pcb_ctrl.sv
// ---------------------------------------------------------------------------
// pcb_ctrl: sequencer for the point clip test
// Takes words, holds the count registers, walks box then plane entries one
// table read a cycle, waits for the pipeline to drain and presents results.
// ---------------------------------------------------------------------------
module pcb_ctrl import pcb_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ctl_cmd_t   cmd,
  input  ctl_sts_t   sts
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t        state_r;
  logic [5:0]    box_count_r, plane_count_r;
  logic [CW-1:0] e_r, nbox, npln;
  logic [3:0]    j_r;
  logic [1:0]    col_r;
  logic          plane_r;
  logic          out_valid_r, out_valid_nxt;
  logic          accept, is_query, ent_last, drain_done;

  // counts above the table depth act as the depth
  assign nbox = ({26'b0, box_count_r} > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(box_count_r);
  assign npln = ({26'b0, plane_count_r} > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
                                                       : CW'(plane_count_r);

  // handshakes
  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign is_query   = in_cmd == CMD_QUERY;
  assign out_valid  = out_valid_r;
  assign drain_done = (state_r == ST_DRAIN) && !sts.pipe_busy;
  assign ent_last   = CW'(e_r + 1'b1) == (plane_r ? npln : nbox);

  // result word held until taken, set by a finished word
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((accept && !is_query) || drain_done) out_valid_nxt = 1'b1;
  end

  // datapath commands
  always_comb begin
    cmd.accept      = accept;
    cmd.query_start = accept && is_query;
    cmd.load_zero   = accept && !is_query;
    cmd.load_result = drain_done;
    cmd.iss.entry   = 8'(e_r);
    cmd.iss.col     = col_r;
    cmd.iss.op      = OP_NONE;
    cmd.iss.word    = j_r;
    if (state_r == ST_RUN) begin
      if (plane_r) begin
        cmd.iss.op = OP_PLN_NRM;
      end else if (j_r < BOX_OFS_STEPS) begin
        cmd.iss.op = OP_BOX_OFS;
      end else begin
        cmd.iss.op   = OP_BOX_MAT;
        cmd.iss.word = j_r - BOX_OFS_STEPS;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      box_count_r   <= '0;
      plane_count_r <= '0;
      e_r           <= '0;
      j_r           <= '0;
      col_r         <= '0;
      plane_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index) plane_count_r <= cfg_data;
        else           box_count_r   <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            e_r   <= '0;
            j_r   <= '0;
            col_r <= '0;
            if (is_query && nbox != '0) begin
              plane_r <= 1'b0;
              state_r <= ST_RUN;
            end else if (is_query && npln != '0) begin
              plane_r <= 1'b1;
              state_r <= ST_RUN;
            end else if (is_query) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_RUN: begin
          col_r <= (col_r == COL_LAST) ? 2'd0 : col_r + 2'd1;
          if (j_r == (plane_r ? PLN_STEPS_LAST : BOX_STEPS_LAST)) begin
            j_r <= '0;
            if (ent_last) begin
              e_r <= '0;
              if (!plane_r && npln != '0) plane_r <= 1'b1;
              else                         state_r <= ST_DRAIN;
            end else begin
              e_r <= e_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iss.op != OP_NONE |-> state_r == ST_RUN)
    else $error("table read issued outside run");
  a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> out_valid_r && state_r == ST_IDLE)
    else $error("drained query gave no result");

endmodule

### hw/rtl/point_clip_test_boxes_planes.sv
// ---------------------------------------------------------------------------
// point_clip_test_boxes_planes: point clip test against boxes and planes
// Loads box and plane tables word by word and tells for each query point
// whether it is clipped by a box, a plane or the polygon bit.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | cmd, entry/word index, value, pos, slot, poly
//  out_    | output    | out_valid/out_stall| cut, cause
//  cfg_    | input     | cfg_valid/cfg_ready| index (box_count, plane_count), data
//
//  a write or unused word gives its result word the cycle after acceptance
//  a query is paced by the single shared multiplier: one table entry per cycle,
//  12 per box and 3 per plane in use; with both counts zero no table is read
//  one item is in flight at a time; the input stalls while a query walks the
//  tables or drains the pipeline and while a result word is held by out_stall
//  rst_n is synchronous; tables hold no reset value until written
// ---------------------------------------------------------------------------
module point_clip_test_boxes_planes import pcb_pkg::*; #(
  parameter int MAX_ENTRIES = 32,
  parameter int MODEL_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [4:0]         in_entry_index,
  input  logic [3:0]         in_word_index,
  input  logic signed [31:0] in_word_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [3:0]         in_model_slot,
  input  logic               in_polygon_cut,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_cut,
  output logic [1:0]         out_cause
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // sequencer
  pcb_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // tables and arithmetic
  pcb_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MODEL_SLOTS(MODEL_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_word_index  (in_word_index),
    .in_word_value  (in_word_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_model_slot  (in_model_slot),
    .in_polygon_cut (in_polygon_cut),
    .cmd            (cmd),
    .sts            (sts),
    .out_cut        (out_cut),
    .out_cause      (out_cause)
  );

endmodule
